// ----- sv/blvr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the bounded list with value removal.
package blvr_pkg;

  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_BACK  = 3'd1;
  localparam logic [2:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [2:0] CMD_DEL_BACK  = 3'd3;
  localparam logic [2:0] CMD_DEL_VALUE = 3'd4;
  localparam logic [2:0] CMD_READ_OUT  = 3'd5;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } state_t;

  typedef struct packed {
    logic signed [31:0] item;
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic               last;
  } res_t;

endpackage

// ----- sv/blvr_mem.sv -----
`timescale 1ns / 1ps
// Entry memory: one write port, one read port with registered read data.
module blvr_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [31:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/blvr_ctrl.sv -----
`timescale 1ns / 1ps
// Command sequencer: ring pointers, scan and shift pass, read out and result register.
module blvr_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output blvr_pkg::res_t     out_res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic signed [31:0] mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic signed [31:0] mem_rdata
);
  import blvr_pkg::*;

  localparam logic [AW+1:0] CAP_P  = (AW+2)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] ONE_C  = CW'(1);

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [AW+1:0] s;
    s = {2'b00, h} + {{(AW+2-CW){1'b0}}, k};
    if (s >= CAP_P) begin
      s = s - CAP_P;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [4:0] cnt5(input logic [CW-1:0] c);
    logic [CW+4:0] t;
    t = {5'b00000, c};
    return t[4:0];
  endfunction

  state_t             state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      sidx_r, sidx_nxt;
  logic               found_r, found_nxt;
  logic               sdv_r, sdv_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_r, out_nxt;
  logic signed [31:0] val_r, val_nxt;

  logic out_free, accept, cnt_full, cnt_empty;
  logic scan_done, rd_load, rd_done, match;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign cnt_full  = (cnt_r == CAP_C);
  assign cnt_empty = (cnt_r == '0);
  assign scan_done = sdv_r && (idx_r == cnt_r);
  assign rd_load   = pend_r && out_free;
  assign rd_done   = rd_load && (idx_r == cnt_r);
  assign match     = (mem_rdata == val_r);

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !cnt_empty) begin
          if (in_command == CMD_DEL_VALUE) begin
            state_nxt = ST_SCAN;
          end else if (in_command == CMD_READ_OUT) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (rd_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    sidx_nxt      = sidx_r;
    found_nxt     = found_r;
    sdv_nxt       = 1'b0;
    pend_nxt      = pend_r;
    val_nxt       = val_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = in_value;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt.item        = '0;
          out_nxt.status      = STAT_OK;
          out_nxt.entry_count = cnt5(cnt_r);
          out_nxt.last        = 1'b1;
          out_valid_nxt       = 1'b1;
          idx_nxt             = '0;
          found_nxt           = 1'b0;
          pend_nxt            = 1'b0;
          val_nxt             = in_value;
          case (in_command)
            CMD_INS_FRONT: begin
              if (cnt_full) begin
                out_nxt.status = STAT_FULL;
              end else begin
                head_nxt            = (head_r == '0) ? LAST_A : head_r - AW'(1);
                mem_we              = 1'b1;
                mem_waddr           = head_nxt;
                cnt_nxt             = cnt_r + ONE_C;
                out_nxt.entry_count = cnt5(cnt_nxt);
              end
            end
            CMD_INS_BACK: begin
              if (cnt_full) begin
                out_nxt.status = STAT_FULL;
              end else begin
                mem_we              = 1'b1;
                mem_waddr           = phys(head_r, cnt_r);
                cnt_nxt             = cnt_r + ONE_C;
                out_nxt.entry_count = cnt5(cnt_nxt);
              end
            end
            CMD_DEL_FRONT: begin
              if (cnt_empty) begin
                out_nxt.status = STAT_EMPTY;
              end else begin
                head_nxt            = phys(head_r, ONE_C);
                cnt_nxt             = cnt_r - ONE_C;
                out_nxt.entry_count = cnt5(cnt_nxt);
              end
            end
            CMD_DEL_BACK: begin
              if (cnt_empty) begin
                out_nxt.status = STAT_EMPTY;
              end else begin
                cnt_nxt             = cnt_r - ONE_C;
                out_nxt.entry_count = cnt5(cnt_nxt);
              end
            end
            CMD_DEL_VALUE, CMD_READ_OUT: begin
              if (cnt_empty) begin
                out_nxt.status = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (idx_r != cnt_r) begin
          mem_re    = 1'b1;
          mem_raddr = phys(head_r, idx_r);
          idx_nxt   = idx_r + ONE_C;
          sidx_nxt  = idx_r;
          sdv_nxt   = 1'b1;
        end
        if (sdv_r) begin
          if (found_r) begin
            mem_we    = 1'b1;
            mem_waddr = phys(head_r, sidx_r - ONE_C);
            mem_wdata = mem_rdata;
          end else if (match) begin
            found_nxt = 1'b1;
          end
        end
        if (scan_done) begin
          cnt_nxt             = found_nxt ? cnt_r - ONE_C : cnt_r;
          out_nxt.item        = '0;
          out_nxt.status      = found_nxt ? STAT_OK : STAT_NOT_FOUND;
          out_nxt.entry_count = cnt5(cnt_nxt);
          out_nxt.last        = 1'b1;
          out_valid_nxt       = 1'b1;
        end
      end
      ST_READ: begin
        if (rd_load) begin
          out_nxt.item        = mem_rdata;
          out_nxt.status      = STAT_OK;
          out_nxt.entry_count = cnt5(cnt_r);
          out_nxt.last        = (idx_r == cnt_r);
          out_valid_nxt       = 1'b1;
          pend_nxt            = 1'b0;
        end
        if ((idx_r != cnt_r) && (!pend_r || rd_load)) begin
          mem_re    = 1'b1;
          mem_raddr = phys(head_r, idx_r);
          idx_nxt   = idx_r + ONE_C;
          pend_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      sdv_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      sdv_r       <= sdv_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    val_r  <= val_nxt;
    sidx_r <= sidx_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LAST_A)
    else $error("head pointer out of range");

  a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !out_valid_r)
    else $error("result pending during scan");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("write and read hit the same entry");

  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> (cnt_r == $past(cnt_r)) || (state_r == ST_IDLE))
    else $error("count changed in the middle of a scan");

endmodule

// ----- sv/bounded_list_with_value_removal_top.sv -----
`timescale 1ns / 1ps
// Bounded list top level: entry memory plus command sequencer.
// Insert, delete front/back and unknown commands: result registered at accept.
// Delete value: scan and shift pass over all entries, then the result; empty list: empty status.
// Read out: one word per cycle in list order while out_ready is high; empty list: empty status.
// Next command accepted once the sequencer is idle and the result register can take a word.
// Reset clears count, head pointer and control; entry memory contents stay undefined.
module bounded_list_with_value_removal_top #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_item,
  output logic [1:0]         out_status,
  output logic [4:0]         out_entry_count,
  output logic               out_last
);
  import blvr_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic signed [31:0] mem_wdata, mem_rdata;
  res_t               res;

  blvr_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  blvr_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_command(in_command),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  assign out_item        = res.item;
  assign out_status      = res.status;
  assign out_entry_count = res.entry_count;
  assign out_last        = res.last;

endmodule
